>>> rtl/core/sem_pkg.sv
// Shared constants and types for the Sobel edge magnitude block.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package sem_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_CAP = 4096;
  localparam int WID_W      = 11;                              // frame_width register
  localparam int HGT_W      = 13;                              // frame_height register
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_CAP + 3);
  localparam int CMP_W      = ROW_W + 1;
  localparam int CNT_W      = ((COL_W > WID_W) ? COL_W : WID_W) + 1;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } sem_cfg_e;

  // Datapath
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int CH_N    = 3;
  localparam int GRAD_W  = 11;
  localparam int SUM_W   = 21;
  localparam int MAG_MAX = 255;
  localparam int RAD_W   = 16;
  localparam int SQRT_STAGES = RAD_W / 2;
  localparam int Q_DEPTH = 4;

  typedef logic [PIX_W-1:0] sem_pix_t;

  // One raster step handed from the front to the back
  typedef struct packed {
    logic [COL_W-1:0] addr;
    sem_pix_t         pix;
    logic             prod;   // step yields a result
    logic             zc0;    // blank left column
    logic             zc2;    // blank right column
    logic             zr0;    // blank top row
    logic             zr2;    // blank bottom row
    logic             fend;   // last result of the frame
  } sem_op_t;

endpackage

>>> rtl/core/sem_front.sv
// Front end: config registers, raster counters and step classification.
// Depends on sem_pkg; feeds sem_queue.
`timescale 1ns / 1ps

module sem_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         action_i,
  input  logic [sem_pkg::CH_W-1:0]     red_i,
  input  logic [sem_pkg::CH_W-1:0]     green_i,
  input  logic [sem_pkg::CH_W-1:0]     blue_i,
  input  logic                         cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output sem_pkg::sem_op_t             q_op_o
);
  import sem_pkg::*;

  logic [WID_W-1:0] width_q, width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             done_q, done_d;
  logic             again_q, again_d;

  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;
  logic [CMP_W-1:0] rw, hw;
  logic [COL_W-1:0] bc;
  logic [ROW_W-1:0] br;
  logic [CNT_W-1:0] nc;
  logic             past_frame, take, pix_go, drn_go, restart_pix, issue;
  logic             edge_st, norm_st;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = HGT_W'(1);
    end else if (32'(height_q) > 32'(HEIGHT_CAP)) begin
      eff_h = HGT_W'(HEIGHT_CAP);
    end else begin
      eff_h = height_q;
    end
  end

  assign hw          = CMP_W'(eff_h);
  assign past_frame  = CMP_W'(row_q) >= hw;
  assign full_o      = q_full_i || again_q;
  assign take        = push_i && !full_o;
  assign pix_go      = take && !action_i;
  assign drn_go      = take && action_i && past_frame && !done_q;
  assign restart_pix = pix_go && past_frame;
  assign issue       = pix_go || drn_go || (again_q && !q_full_i);

  always_comb begin
    bc = restart_pix ? '0 : col_q;
    br = restart_pix ? '0 : row_q;
    rw = CMP_W'(br);

    edge_st = (bc == '0) && (rw >= CMP_W'(2)) && (rw < hw + CMP_W'(2));
    norm_st = (bc != '0) && (rw >= CMP_W'(1)) && (rw <= hw);

    q_op_o.addr = bc;
    q_op_o.pix  = pix_go ? {red_i, green_i, blue_i} : '0;
    q_op_o.prod = edge_st || norm_st;
    q_op_o.zc0  = edge_st ? (eff_w < WID_W'(2)) : (bc == COL_W'(1));
    q_op_o.zc2  = edge_st;
    q_op_o.zr0  = edge_st ? (rw < CMP_W'(3)) : (rw < CMP_W'(2));
    q_op_o.zr2  = edge_st ? (rw >= hw + CMP_W'(1)) : (rw >= hw);
    q_op_o.fend = edge_st && (rw == hw + CMP_W'(1));
    q_push_o    = issue;

    nc = CNT_W'(bc) + CNT_W'(1);

    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = done_q;
    again_d  = again_q ? q_full_i : (drn_go && !q_op_o.prod);

    if (issue) begin
      if (nc >= CNT_W'(eff_w)) begin
        col_d = '0;
        row_d = br + ROW_W'(1);
      end else begin
        col_d = nc[COL_W-1:0];
        row_d = br;
      end
      done_d = (done_q && !restart_pix) || q_op_o.fend;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH: begin
          width_d = cfg_data_i[WID_W-1:0];
          col_d = '0;
          row_d = '0;
          done_d = 1'b0;
          again_d = 1'b0;
        end
        CFG_HEIGHT: begin
          height_d = cfg_data_i[HGT_W-1:0];
          col_d = '0;
          row_d = '0;
          done_d = 1'b0;
          again_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(640);
      height_q <= HGT_W'(480);
      col_q    <= '0;
      row_q    <= '0;
      done_q   <= 1'b0;
      again_q  <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      done_q   <= done_d;
      again_q  <= again_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a second drain step only follows a drain that produced nothing
  a_again_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(again_q) |-> $past(drn_go))
    else $error("second drain step without a drain beat");

  a_again_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    again_q |-> (past_frame && !done_q))
    else $error("second drain step outside the frame tail");
`endif

endmodule

>>> rtl/core/sem_queue.sv
// Short step queue between the front end and the back end.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sem_pkg::sem_op_t op_i,
  output logic             full_o,
  input  logic             pop_i,
  output sem_pkg::sem_op_t op_o,
  output logic             empty_o
);
  import sem_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W  = $clog2(Q_DEPTH + 1);

  sem_op_t          mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QC_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("step pushed into a full queue");
`endif

endmodule

>>> rtl/core/sem_sqrt.sv
// Pipelined rounded square root of a gradient energy, clamped at 255.
// Depends on sem_pkg; one restoring step per stage, SQRT_STAGES deep.
`timescale 1ns / 1ps

module sem_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sem_pkg::SUM_W-1:0]   sum_i,
  output logic [sem_pkg::CH_W-1:0]    mag_o
);
  import sem_pkg::*;

  localparam int RT_W = RAD_W + 1;
  localparam int CLAMP_LIM = MAG_MAX * (MAG_MAX + 1);

  typedef struct packed {
    logic [RT_W-1:0] x;
    logic [RT_W-1:0] r;
  } sqs_t;

  function automatic sqs_t sq_step(sqs_t a, logic [RT_W-1:0] b);
    sqs_t            o;
    logic [RT_W-1:0] t;
    t = a.r + b;
    if (a.x >= t) begin
      o.x = a.x - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.x = a.x;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  sqs_t                   st_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] cl_q;
  sqs_t                   init;
  logic                   clamp;
  logic                   rnd;

  // above 255*256 the rounded root is at least 256
  assign clamp  = sum_i > SUM_W'(CLAMP_LIM);
  assign init.x = clamp ? '0 : RT_W'(sum_i[RAD_W-1:0]);
  assign init.r = '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sq_step(init, RT_W'(1) << (RAD_W - 2));
      cl_q    <= {cl_q[SQRT_STAGES-2:0], clamp};
    end
  end

  for (genvar k = 1; k < SQRT_STAGES; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= sq_step(st_q[k-1], RT_W'(1) << (RAD_W - 2 - 2 * k));
      end
    end
  end

  // remainder above the root means the sum lies past r*r+r
  assign rnd   = st_q[SQRT_STAGES-1].x > st_q[SQRT_STAGES-1].r;
  assign mag_o = cl_q[SQRT_STAGES-1] ? CH_W'(MAG_MAX)
                                     : st_q[SQRT_STAGES-1].r[CH_W-1:0] + CH_W'(rnd);

endmodule

>>> rtl/core/sem_back.sv
// Back end: line stores, 3x3 window, Sobel sums, energy and root, result register.
// Depends on sem_pkg and sem_sqrt; takes steps from sem_queue.
`timescale 1ns / 1ps

module sem_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  sem_pkg::sem_op_t         q_op_i,
  output logic                     q_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [sem_pkg::CH_W-1:0] edge_red_o,
  output logic [sem_pkg::CH_W-1:0] edge_green_o,
  output logic [sem_pkg::CH_W-1:0] edge_blue_o,
  output logic                     frame_end_o
);
  import sem_pkg::*;

  sem_pix_t upper_mem [MAX_WIDTH];
  sem_pix_t middle_mem [MAX_WIDTH];
  sem_pix_t rd_up_q, rd_mid_q, last_up_q, last_mid_q;

  logic     en;
  logic     b_v_q, b_fwd_q;
  sem_op_t  b_op_q;
  sem_pix_t top, mid;
  sem_pix_t win_q [3][3];
  sem_pix_t win_n [3][3];
  sem_pix_t msk [3][3];

  sem_pix_t c_win_q [3][3];
  logic     c_v_q, c_f_q, d_v_q, d_f_q, e_v_q, e_f_q;
  logic [SQRT_STAGES-1:0] sv_q, sf_q;

  logic signed [GRAD_W-1:0] gx_q [CH_N];
  logic signed [GRAD_W-1:0] gy_q [CH_N];
  logic [SUM_W-1:0]         s_q [CH_N];
  logic [CH_W-1:0]          mag [CH_N];
  logic [CH_W-1:0]          out_q [CH_N];
  logic                     out_v_q, out_f_q;

  // whole back pipeline moves when the result register is free or leaving
  assign en      = !out_v_q || pop_i;
  assign q_pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_up_q  <= upper_mem[q_op_i.addr];
      rd_mid_q <= middle_mem[q_op_i.addr];
    end
    if (en && b_v_q) begin
      upper_mem[b_op_q.addr]  <= mid;
      middle_mem[b_op_q.addr] <= b_op_q.pix;
      last_up_q  <= mid;
      last_mid_q <= b_op_q.pix;
    end
    if (en) begin
      b_op_q <= q_op_i;
    end
  end

  // bypass the store when the step before hit the same column
  assign top = b_fwd_q ? last_up_q : rd_up_q;
  assign mid = b_fwd_q ? last_mid_q : rd_mid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_n[i][0] = win_q[i][1];
      win_n[i][1] = win_q[i][2];
    end
    win_n[0][2] = top;
    win_n[1][2] = mid;
    win_n[2][2] = b_op_q.pix;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        msk[i][j] = win_n[i][j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (b_op_q.zc0) msk[i][0] = '0;
      if (b_op_q.zc2) msk[i][2] = '0;
      if (b_op_q.zr0) msk[0][i] = '0;
      if (b_op_q.zr2) msk[2][i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      b_fwd_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (en) begin
      b_v_q   <= !q_empty_i;
      b_fwd_q <= b_v_q && (b_op_q.addr == q_op_i.addr);
      if (b_v_q) begin
        win_q <= win_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_win_q <= msk;
      c_f_q   <= b_op_q.fend;
      d_f_q   <= c_f_q;
      e_f_q   <= d_f_q;
      sf_q    <= {sf_q[SQRT_STAGES-2:0], e_f_q};
      out_f_q <= sf_q[SQRT_STAGES-1];
      out_q   <= mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      sv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      c_v_q   <= b_v_q && b_op_q.prod;
      d_v_q   <= c_v_q;
      e_v_q   <= d_v_q;
      sv_q    <= {sv_q[SQRT_STAGES-2:0], e_v_q};
      out_v_q <= sv_q[SQRT_STAGES-1];
    end
  end

  for (genvar ch = 0; ch < CH_N; ch++) begin : g_ch
    localparam int LSB = PIX_W - CH_W * (ch + 1);
    logic [CH_W-1:0]   p [3][3];
    logic [CH_W+1:0]   xp, xn, yp, yn;
    logic signed [2*GRAD_W-1:0] sqx, sqy;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] = c_win_q[i][j][LSB +: CH_W];
        end
      end
      xp = (CH_W+2)'(p[0][2]) + {1'b0, p[1][2], 1'b0} + (CH_W+2)'(p[2][2]);
      xn = (CH_W+2)'(p[0][0]) + {1'b0, p[1][0], 1'b0} + (CH_W+2)'(p[2][0]);
      yp = (CH_W+2)'(p[2][0]) + {1'b0, p[2][1], 1'b0} + (CH_W+2)'(p[2][2]);
      yn = (CH_W+2)'(p[0][0]) + {1'b0, p[0][1], 1'b0} + (CH_W+2)'(p[0][2]);
    end

    assign sqx = gx_q[ch] * gx_q[ch];
    assign sqy = gy_q[ch] * gy_q[ch];

    always_ff @(posedge clk_i) begin
      if (en) begin
        gx_q[ch] <= $signed({1'b0, xp}) - $signed({1'b0, xn});
        gy_q[ch] <= $signed({1'b0, yp}) - $signed({1'b0, yn});
        s_q[ch]  <= sqx[SUM_W-1:0] + sqy[SUM_W-1:0];
      end
    end

    sem_sqrt u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .sum_i (s_q[ch]),
      .mag_o (mag[ch])
    );
  end

  assign empty_o      = !out_v_q;
  assign edge_red_o   = out_q[0];
  assign edge_green_o = out_q[1];
  assign edge_blue_o  = out_q[2];
  assign frame_end_o  = out_f_q;

endmodule

>>> rtl/core/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
`timescale 1ns / 1ps

// Pixels enter in raster order as pixel beats (action 0); each result is the
// rounded, clamped Sobel gradient magnitude per color channel of the pixel one
// line and one pixel behind. After the last pixel of a frame, each drain beat
// (action 1) releases one pending result. The block takes one beat per clock
// while results are popped every cycle; a drain beat that has to step over an
// empty raster position holds full high until its second step enters the step
// queue. A step that leaves the step queue passes the line store read, window,
// Sobel sums, energy, an 8-stage root pipeline and the result register on its
// way to the output. The two line stores are 1024 x 24 memories with one read
// and one write per cycle each; they need no clearing after reset.
// Write the frame registers only while idle; any valid write restarts the frame.
module sobel_edge_magnitude_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          action_i,
  input  logic [sem_pkg::CH_W-1:0]      red_i,
  input  logic [sem_pkg::CH_W-1:0]      green_i,
  input  logic [sem_pkg::CH_W-1:0]      blue_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sem_pkg::CH_W-1:0]      edge_red_o,
  output logic [sem_pkg::CH_W-1:0]      edge_green_o,
  output logic [sem_pkg::CH_W-1:0]      edge_blue_o,
  output logic                          frame_end_o,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i
);
  import sem_pkg::*;

  logic    q_push, q_full, q_pop, q_empty;
  sem_op_t q_in, q_out;

  sem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .action_i   (action_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_in)
  );

  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (q_out),
    .empty_o (q_empty)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_op_i       (q_out),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .edge_red_o   (edge_red_o),
    .edge_green_o (edge_green_o),
    .edge_blue_o  (edge_blue_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

>>> verif/sobel_edge_magnitude_rgb_checker.sv
// Checker for sobel_edge_magnitude_rgb: watches the pixel, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on sem_pkg for widths and register indexes.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  logic                          action_i,
  input  logic [sem_pkg::CH_W-1:0]      red_i,
  input  logic [sem_pkg::CH_W-1:0]      green_i,
  input  logic [sem_pkg::CH_W-1:0]      blue_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [sem_pkg::CH_W-1:0]      edge_red_i,
  input  logic [sem_pkg::CH_W-1:0]      edge_green_i,
  input  logic [sem_pkg::CH_W-1:0]      edge_blue_i,
  input  logic                          frame_end_i,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import sem_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            fend;
  } edge_px_t;

  // 3x3 neighborhood, entry row*3+col
  typedef logic [8:0][PIX_W-1:0] nbhd_t;

  edge_px_t    edges_due[$];
  int unsigned width_reg, height_reg;
  sem_pix_t    upper_row [MAX_WIDTH];
  sem_pix_t    middle_row [MAX_WIDTH];
  nbhd_t       win;
  int unsigned in_col, in_row, out_col, out_row;

  function automatic int unsigned eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 1) return 1;
    if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
    return height_reg;
  endfunction

  // Nearest integer root, clamped to a channel
  function automatic logic [CH_W-1:0] round_root(int unsigned s);
    int unsigned r;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= s) r = r | (1 << b);
    end
    if (s > r * r + r) r++;
    return (r > MAG_MAX) ? CH_W'(MAG_MAX) : CH_W'(r);
  endfunction

  function automatic edge_px_t gradient(nbhd_t m, int unsigned row, int unsigned col);
    edge_px_t res;
    int p [9];
    int gx, gy;
    int unsigned w, h;
    logic [CH_W-1:0] mag [3];
    w = eff_width();
    h = eff_height();
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) p[k] = int'(m[k][16-8*ch +: 8]);
      gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
      gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
      mag[ch] = round_root(int'(gx * gx + gy * gy));
    end
    res.red   = mag[0];
    res.green = mag[1];
    res.blue  = mag[2];
    res.fend  = (row == h - 1 && col == w - 1);
    out_col = col + 1;
    out_row = row;
    if (out_col >= w) begin
      out_col = 0;
      out_row = row + 1;
    end
    return res;
  endfunction

  // One raster position; real pixel or blank position past the frame
  function automatic bit raster_step(sem_pix_t pix, bit is_pixel, output edge_px_t res);
    int unsigned w, h, c, r, ci;
    nbhd_t m;
    bit made;
    w = eff_width();
    h = eff_height();
    c = in_col;
    r = in_row;
    ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    made = 0;
    res = '0;
    // right border of the previous row completes at column zero
    if (c == 0 && r >= 2 && r - 2 < h) begin
      for (int i = 0; i < 3; i++) begin
        m[i*3]   = (w < 2) ? '0 : win[i*3+1];
        m[i*3+1] = win[i*3+2];
        m[i*3+2] = '0;
      end
      if (r < 3) begin
        m[0] = '0;
        m[1] = '0;
      end
      if (r - 1 >= h) begin
        m[6] = '0;
        m[7] = '0;
      end
      res = gradient(m, r - 2, w - 1);
      made = 1;
    end
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_row[ci];
    win[5] = middle_row[ci];
    win[8] = is_pixel ? pix : '0;
    upper_row[ci]  = middle_row[ci];
    middle_row[ci] = win[8];
    if (c >= 1 && r >= 1 && r - 1 < h) begin
      m = win;
      if (c < 2) begin
        m[0] = '0; m[3] = '0; m[6] = '0;
      end
      if (r < 2) begin
        m[0] = '0; m[1] = '0; m[2] = '0;
      end
      if (r >= h) begin
        m[6] = '0; m[7] = '0; m[8] = '0;
      end
      res = gradient(m, r - 1, c - 1);
      made = 1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    in_col = c;
    in_row = r;
    return made;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void predict_beat(logic act, sem_pix_t pix);
    edge_px_t res;
    int unsigned h;
    h = eff_height();
    if (!act) begin
      if (in_row >= h) restart_frame();
      if (raster_step(pix, 1, res)) edges_due.push_back(res);
    end else if (in_row >= h && out_row < h) begin
      while (in_row <= h || (in_row == h + 1 && in_col == 0)) begin
        if (raster_step('0, 0, res)) begin
          edges_due.push_back(res);
          break;
        end
      end
    end
  endfunction

  function automatic void reset_model();
    width_reg = 640;
    height_reg = 480;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    win = '0;
    restart_frame();
    edges_due.delete();
  endfunction

  initial begin
    fail_count_o = 0;
    reset_model();
  end

  always @(posedge clk_i) begin
    edge_px_t want;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (pop && !empty) begin
        if (edges_due.size() == 0) begin
          $error("unexpected result beat: red %0d green %0d blue %0d frame_end %0d",
                 edge_red_i, edge_green_i, edge_blue_i, frame_end_i);
          fail_count_o++;
        end else begin
          want = edges_due.pop_front();
          if (edge_red_i !== want.red) begin
            $error("edge_red: expected %0d, actual %0d", want.red, edge_red_i);
            fail_count_o++;
          end
          if (edge_green_i !== want.green) begin
            $error("edge_green: expected %0d, actual %0d", want.green, edge_green_i);
            fail_count_o++;
          end
          if (edge_blue_i !== want.blue) begin
            $error("edge_blue: expected %0d, actual %0d", want.blue, edge_blue_i);
            fail_count_o++;
          end
          if (frame_end_i !== want.fend) begin
            $error("frame_end: expected %0d, actual %0d", want.fend, frame_end_i);
            fail_count_o++;
          end
        end
      end
      if (push && !full) predict_beat(action_i, {red_i, green_i, blue_i});
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          width_reg = cfg_data_i[WID_W-1:0];
          restart_frame();
        end else if (cfg_idx_i == CFG_HEIGHT) begin
          height_reg = cfg_data_i[HGT_W-1:0];
          restart_frame();
        end
      end
    end
    pending_o = edges_due.size();
  end

endmodule

>>> verif/sobel_edge_magnitude_rgb_tb.sv
// Testbench top for sobel_edge_magnitude_rgb: drives pixel, drain and
// register beats, pops results and gives the verdict.
// Depends on sem_pkg, the block and sobel_edge_magnitude_rgb_checker.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 30;
  localparam logic DO_PIXEL = 1'b0;
  localparam logic DO_DRAIN = 1'b1;

  logic                 clk_i, rst_ni;
  logic                 push, full, empty, pop;
  logic                 action_i;
  logic [CH_W-1:0]      red_i, green_i, blue_i;
  logic [CH_W-1:0]      edge_red_o, edge_green_o, edge_blue_o;
  logic                 frame_end_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_count, pending;
  int                   beats_sent, quiet_cycles, pop_hold;
  bit                   calm;

  sobel_edge_magnitude_rgb dut (.*);

  sobel_edge_magnitude_rgb_checker checker_u (
    .clk_i, .rst_ni, .push, .full, .action_i, .red_i, .green_i, .blue_i,
    .empty, .pop, .edge_red_i(edge_red_o), .edge_green_i(edge_green_o),
    .edge_blue_i(edge_blue_o), .frame_end_i(frame_end_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // result side: random stall bursts, none once calm
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop_hold <= $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sobel_edge_magnitude_rgb: mismatch");
      $finish;
    end
  end

  function automatic logic [CH_W-1:0] pick_chan();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic act, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    action_i <= act;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (full);
    beats_sent++;
  endtask

  task automatic send_pixel();
    send_beat(DO_PIXEL, pick_chan(), pick_chan(), pick_chan());
  endtask

  // drain content is ignored by the block; randomize it anyway
  task automatic send_drain();
    send_beat(DO_DRAIN, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
  endtask

  // drop push, wait for every expected result and any drain still in flight
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic run_frame(int w, int h, int drains);
    for (int i = 0; i < w * h; i++) send_pixel();
    repeat (drains) send_drain();
  endtask

  initial begin
    int w, h, drains;
    bit keep_cfg;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    pop_hold = 0;
    action_i = DO_PIXEL;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_data_i = '0;
    quiet_cycles = 0;
    beats_sent = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: drain while receiving is ignored, then a partial frame
    send_drain();
    repeat (6) send_pixel();
    // 3x3 with saturated corners and a random frame
    set_frame(3, 3);
    send_beat(DO_PIXEL, '1, '0, '1);
    send_beat(DO_PIXEL, '0, '1, '0);
    send_beat(DO_PIXEL, '1, '1, '1);
    send_beat(DO_PIXEL, '0, '0, '0);
    send_drain();
    repeat (5) send_pixel();
    repeat (6) send_drain();
    run_frame(3, 3, 4);
    // zero registers act as one, unused indexes do nothing
    set_frame(0, 0);
    write_reg(CFG_IDX_W'(2), CFG_W'($urandom));
    write_reg(CFG_IDX_W'(3), CFG_W'($urandom));
    run_frame(1, 1, 3);
    send_pixel();
    // widest row, partial: upper bits of width dropped, 2047 clamps to the maximum
    set_frame('1, 1);
    repeat (12) send_pixel();
    // tallest frame, partial; the next write restarts it
    set_frame(1, '1);
    repeat (12) send_pixel();
    set_frame(1, HEIGHT_CAP);
    repeat (5) send_pixel();
    set_frame(2, 2);
    run_frame(2, 2, 1);
    send_pixel(); // new frame while outputs are still pending

    keep_cfg = 0;
    beats_sent = 0;
    while (beats_sent < 375) begin
      if (beats_sent > 310) calm = 1;
      if (!keep_cfg) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        set_frame(CFG_W'(w), CFG_W'(h));
      end
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 15) == 0) send_drain();
        send_pixel();
      end
      keep_cfg = ($urandom_range(0, 5) == 0);
      drains = keep_cfg ? $urandom_range(0, w) : w + 1 + $urandom_range(0, 2);
      repeat (drains) send_drain();
    end
    settle();
    if (fail_count == 0) begin
      $display("sobel_edge_magnitude_rgb: match");
    end else begin
      $display("sobel_edge_magnitude_rgb: mismatch");
    end
    $finish;
  end

endmodule
